// ----- rtl/pixel_replicate_upscaler_macros.svh -----
// Assertion macros used by the upscaler checker file.
`ifndef PIXEL_REPLICATE_UPSCALER_MACROS_SVH
`define PIXEL_REPLICATE_UPSCALER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pru_pkg.sv -----
// Shared types and constants of the pixel replicate upscaler.
package pru_pkg;

  localparam int unsigned PixW      = 24;
  localparam int unsigned ScaleW    = 7;
  localparam int unsigned SrcWidthW = 11;
  localparam int unsigned HeightW   = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 32;
  localparam int unsigned OutUserW  = 2;

  localparam logic [ScaleW-1:0] ScaleLimit = 7'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  // Per-result flags that travel alongside the line store read.
  typedef struct packed {
    logic       valid_res;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       image_end;
  } res_meta_t;

endpackage

// ----- rtl/pru_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pru_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pru_ctrl.sv -----
// Configuration registers, load and fetch counters, line store addressing.
module pru_ctrl import pru_pkg::*; #(
  parameter int unsigned MaxWidth = 1024,
  localparam int unsigned AddrW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1,
  localparam int unsigned CntW  = $clog2(MaxWidth + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_fire_i,
  input  logic                 in_op_i,
  output logic                 ram_we_o,
  output logic [AddrW-1:0]     ram_waddr_o,
  output logic                 ram_re_o,
  output logic [AddrW-1:0]     ram_raddr_o,
  output logic                 res_push_o,
  output res_meta_t            res_meta_o
);

  logic [ScaleW-1:0]    scale_q, scale_d;
  logic [SrcWidthW-1:0] width_q, width_d;
  logic [HeightW-1:0]   height_q, height_d;

  logic [CntW-1:0]    loaded_q, loaded_d;
  logic               ready_q, ready_d;
  logic [AddrW-1:0]   col_q, col_d;
  logic [ScaleW-1:0]  across_q, across_d;
  logic [ScaleW-1:0]  down_q, down_d;
  logic [HeightW-1:0] row_q, row_d;

  logic [ScaleW-1:0]  eff_s;
  logic [CntW-1:0]    eff_w;
  logic [HeightW-1:0] eff_h;
  logic               restart;
  logic               is_load, is_fetch;
  logic [CntW-1:0]    loaded_inc;
  logic               col_last, across_last, down_last, row_last;

  // Clamp the raw registers to their usable ranges.
  always_comb begin
    if (scale_q == '0) begin
      eff_s = ScaleW'(1);
    end else if (scale_q > ScaleLimit) begin
      eff_s = ScaleLimit;
    end else begin
      eff_s = scale_q;
    end
    if (width_q == '0) begin
      eff_w = CntW'(1);
    end else if (32'(width_q) > 32'(MaxWidth)) begin
      eff_w = CntW'(MaxWidth);
    end else begin
      eff_w = CntW'(width_q);
    end
    eff_h = (height_q == '0) ? HeightW'(1) : height_q;
  end

  assign restart  = cfg_we_i && (cfg_idx_e'(cfg_index_i) != CFG_NONE);
  assign is_load  = in_fire_i && (op_e'(in_op_i) == OP_LOAD);
  assign is_fetch = in_fire_i && (op_e'(in_op_i) == OP_FETCH);

  assign loaded_inc  = loaded_q + CntW'(1);
  assign col_last    = (CntW'(col_q) + CntW'(1)) >= eff_w;
  assign across_last = (across_q + ScaleW'(1)) >= eff_s;
  assign down_last   = (down_q + ScaleW'(1)) >= eff_s;
  assign row_last    = ({1'b0, row_q} + (HeightW + 1)'(1)) >= {1'b0, eff_h};

  always_comb begin
    scale_d  = scale_q;
    width_d  = width_q;
    height_d = height_q;
    loaded_d = loaded_q;
    ready_d  = ready_q;
    col_d    = col_q;
    across_d = across_q;
    down_d   = down_q;
    row_d    = row_q;
    if (restart) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SCALE:  scale_d  = cfg_data_i[ScaleW-1:0];
        CFG_WIDTH:  width_d  = cfg_data_i[SrcWidthW-1:0];
        CFG_HEIGHT: height_d = cfg_data_i;
        default:    ;
      endcase
      loaded_d = '0;
      ready_d  = 1'b0;
      col_d    = '0;
      across_d = '0;
      down_d   = '0;
      row_d    = '0;
    end else if (is_load && !ready_q) begin
      if (loaded_inc >= eff_w || loaded_q >= eff_w) begin
        loaded_d = '0;
        ready_d  = 1'b1;
        col_d    = '0;
        across_d = '0;
        down_d   = '0;
      end else begin
        loaded_d = loaded_inc;
      end
    end else if (is_fetch && ready_q) begin
      if (across_last) begin
        across_d = '0;
        if (col_last) begin
          col_d = '0;
          if (down_last) begin
            down_d  = '0;
            ready_d = 1'b0;
            row_d   = row_last ? '0 : row_q + HeightW'(1);
          end else begin
            down_d = down_q + ScaleW'(1);
          end
        end else begin
          col_d = col_q + AddrW'(1);
        end
      end else begin
        across_d = across_q + ScaleW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= ScaleW'(1);
      width_q  <= SrcWidthW'(1);
      height_q <= HeightW'(1);
      loaded_q <= '0;
      ready_q  <= 1'b0;
      col_q    <= '0;
      across_q <= '0;
      down_q   <= '0;
      row_q    <= '0;
    end else begin
      scale_q  <= scale_d;
      width_q  <= width_d;
      height_q <= height_d;
      loaded_q <= loaded_d;
      ready_q  <= ready_d;
      col_q    <= col_d;
      across_q <= across_d;
      down_q   <= down_d;
      row_q    <= row_d;
    end
  end

  // Line store write on load, read on a fetch of a loaded row.
  assign ram_we_o    = is_load && !ready_q && (loaded_q < eff_w);
  assign ram_waddr_o = loaded_q[AddrW-1:0];
  assign ram_re_o    = is_fetch && ready_q;
  assign ram_raddr_o = col_q;

  // Every fetch yields one result; an unloaded row gives an all-zero one.
  assign res_push_o = is_fetch;
  always_comb begin
    res_meta_o = '0;
    if (ready_q) begin
      res_meta_o.valid_res = 1'b1;
      if (col_last && across_last) begin
        res_meta_o.row_end   = 1'b1;
        // Pad = (4 - 3*w*s mod 4) mod 4, which reduces to w*s mod 4.
        res_meta_o.pad_bytes = 2'(eff_w[1:0] * eff_s[1:0]);
        res_meta_o.image_end = down_last && row_last;
      end
    end
  end

endmodule

// ----- rtl/pru_pipe.sv -----
// Read-data stage and output register with stall handling.
module pru_pipe import pru_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  res_meta_t           meta_i,
  input  logic [PixW-1:0]     rdata_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixW-1:0]     out_pix_o,
  output res_meta_t           out_meta_o
);

  logic            s2_valid_q, s2_valid_d;
  res_meta_t       s2_meta_q;
  logic            s3_valid_q, s3_valid_d;
  res_meta_t       s3_meta_q;
  logic [PixW-1:0] s3_pix_q;
  logic            s2_move;

  // The RAM read register holds while s2 waits, since no read is issued then.
  assign s2_move    = s2_valid_q && (!s3_valid_q || out_ready_i);
  assign take_o     = !s2_valid_q || s2_move;
  assign s2_valid_d = push_i || (s2_valid_q && !s2_move);
  assign s3_valid_d = s2_move || (s3_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      s3_valid_q <= s3_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      s2_meta_q <= meta_i;
    end
    if (s2_move) begin
      s3_meta_q <= s2_meta_q;
      s3_pix_q  <= s2_meta_q.valid_res ? rdata_i : '0;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_pix_o   = s3_pix_q;
  assign out_meta_o  = s3_meta_q;

endmodule

// ----- rtl/pixel_replicate_upscaler.sv -----
// Top level of the nearest-neighbor integer pixel upscaler.
//
//  channel  direction  handshake                      payload
//  s_axis   in         s_axis_tvalid / s_axis_tready  tdata {red,green,blue}, tuser op
//  m_axis   out        m_axis_tvalid / m_axis_tready  tdata pixel+pad, tuser flags, tlast
//  cfg      in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item per cycle sustained while m_axis does not stall: load and fetch both
// pass the counter stage, then a fetch's result is held first in the line store
// read register and then in the output register.
// Reset (rst_ni low) clears all counters and sets every config register to 1.
// Output stalls back up through the read stage; s_axis_tready drops only when
// both result stages are full and m_axis_tready is low. cfg is always ready.
module pixel_replicate_upscaler import pru_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Load/fetch items.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] blue, [15:8] green, [23:16] red
  input  logic [0:0]          s_axis_tuser,   // [0] op
  // Result items.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] out_blue, [15:8] out_green,
                                              // [23:16] out_red, [25:24] pad_bytes, rest 0
  output logic [OutUserW-1:0] m_axis_tuser,   // [0] valid_res, [1] image_end
  output logic                m_axis_tlast,   // row_end
  // Configuration writes.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic             in_fire;
  logic             take;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [PixW-1:0]  ram_rdata;
  logic             res_push;
  res_meta_t        res_meta;
  logic [PixW-1:0]  out_pix;
  res_meta_t        out_meta;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = take;
  assign in_fire       = s_axis_tvalid && take;

  // Counters and addressing; loads advance until the row is loaded, fetches after that.
  pru_ctrl #(
    .MaxWidth (MAX_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .in_op_i     (s_axis_tuser[0]),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .res_push_o  (res_push),
    .res_meta_o  (res_meta)
  );

  // One source row, stored as {red, green, blue}.
  pru_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata[PixW-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read stage plus output register; hold results while the sink stalls.
  pru_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .meta_i      (res_meta),
    .rdata_i     (ram_rdata),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (out_pix),
    .out_meta_o  (out_meta)
  );

  // Pack the result item.
  assign m_axis_tdata = {(OutDataW - PixW - 2)'(0), out_meta.pad_bytes, out_pix};
  assign m_axis_tuser = {out_meta.image_end, out_meta.valid_res};
  assign m_axis_tlast = out_meta.row_end;

endmodule

// ----- rtl/pru_checker.sv -----
// Port-level checks on the upscaler result stream, bound to the top level.
`include "pixel_replicate_upscaler_macros.svh"

module pru_checker import pru_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [OutUserW-1:0] m_axis_tuser,
  input logic                m_axis_tlast
);

  `PRU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result item changed")
  `PRU_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0 && !m_axis_tlast && !m_axis_tuser[1], "unloaded fetch result not all zero")
  `PRU_ASSERT_IMPL(a_image_row, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "image end without row end")
  `PRU_ASSERT_IMPL(a_pad_row, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[25:24] == 2'd0, "pad bytes off row end")
  `PRU_ASSERT_IMPL(a_high_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[OutDataW-1:26] == '0, "fill bits of result not zero")

endmodule

bind pixel_replicate_upscaler pru_checker u_pru_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
